### rtl/fqd_pkg.sv
// Package for the FIFO queue with delete: sizes, command and status codes,
// cell control struct and the request/response payload types.
// No dependencies.
`timescale 1ns / 1ps

package fqd_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_DEL  = 2'd2,
		CMD_ITER = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_ZERO      = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SHIFT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_ITER
	} fsm_t;

	typedef struct packed {
		cell_op_t              op;
		logic [DATA_WIDTH-1:0] word;
		logic [CNT_W-1:0]      count;
	} cell_ctl_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [DATA_WIDTH-1:0] data_in;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] data_out;
		logic                  item_valid;
		logic [CNT_W-1:0]      count;
		logic                  last;
	} rsp_t;

endpackage

### rtl/fqd_cell.sv
// One storage cell of the queue chain: holds one word, compares it against
// the broadcast word and takes data from its upper neighbor. Uses fqd_pkg.
`timescale 1ns / 1ps

module fqd_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  fqd_pkg::cell_ctl_t            ctl,
	input  logic [fqd_pkg::DATA_WIDTH-1:0] head,
	input  logic [fqd_pkg::DATA_WIDTH-1:0] upper,
	input  logic                          found_in,
	output logic                          found_out,
	output logic [fqd_pkg::DATA_WIDTH-1:0] data
);
	import fqd_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  occ;
	logic                  at_tail;
	logic                  is_newest;
	logic                  match;

	assign occ       = CNT_W'(IDX) < ctl.count;
	assign at_tail   = CNT_W'(IDX) == ctl.count;
	assign is_newest = CNT_W'(IDX + 1) == ctl.count;
	assign match     = occ && (data_q == ctl.word);
	// set if any occupied cell at or below this one matches
	assign found_out = found_in | match;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_LOAD: begin
				if (at_tail) begin
					data_q <= ctl.word;
				end
			end
			OP_SHIFT: begin
				data_q <= upper;
			end
			OP_DELETE: begin
				if (found_out) begin
					data_q <= upper;
				end
			end
			OP_ROTATE: begin
				// move head to the newest slot, advance the rest
				if (is_newest) begin
					data_q <= head;
				end else if (occ) begin
					data_q <= upper;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/fifo_queue_with_delete.sv
// A bounded FIFO of nonzero words with enqueue, dequeue, delete of the first
// equal entry (order kept) and iterate. Enqueue, dequeue and delete each give
// one response the cycle after start; every cell compares and shifts in
// parallel. Iterate gives one response per stored word (one if empty) on
// consecutive cycles by rotating the cell chain count times; busy is high
// until the final response, so an iterate holds the input while it runs.
// Responses are one-cycle strobes on rsp_valid and cannot be stalled.
`timescale 1ns / 1ps

module fifo_queue_with_delete (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fqd_pkg::req_t req,
	output logic          rsp_valid,
	output fqd_pkg::rsp_t rsp
);
	import fqd_pkg::*;

	fsm_t             state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic             rsp_valid_q, rsp_valid_d;
	rsp_t             rsp_q, rsp_d;
	cell_ctl_t        ctl;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH:0]        found;
	logic                  accept;
	logic                  word_zero;

	assign found[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] upper;
		if (i == DEPTH - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_data[i + 1];
		end
		fqd_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.head     (cell_data[0]),
			.upper    (upper),
			.found_in (found[i]),
			.found_out(found[i + 1]),
			.data     (cell_data[i])
		);
	end

	assign accept    = start && (state_q == FSM_IDLE);
	assign word_zero = req.data_in == '0;
	assign busy      = state_q == FSM_ITER;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		left_d      = left_q;
		rsp_valid_d = 1'b0;
		rsp_d       = rsp_q;
		ctl.op      = OP_HOLD;
		ctl.word    = req.data_in;
		ctl.count   = count_q;

		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					rsp_valid_d      = 1'b1;
					rsp_d.status     = STAT_OK;
					rsp_d.data_out   = '0;
					rsp_d.item_valid = 1'b0;
					rsp_d.last       = 1'b1;
					unique case (req.cmd)
						CMD_ENQ: begin
							if (word_zero) begin
								rsp_d.status = STAT_ZERO;
							end else if (count_q == CNT_W'(DEPTH)) begin
								rsp_d.status = STAT_FULL;
							end else begin
								ctl.op  = OP_LOAD;
								count_d = count_q + 1'b1;
							end
						end
						CMD_DEQ: begin
							if (count_q == '0) begin
								rsp_d.status = STAT_EMPTY;
							end else begin
								ctl.op           = OP_SHIFT;
								count_d          = count_q - 1'b1;
								rsp_d.data_out   = cell_data[0];
								rsp_d.item_valid = 1'b1;
							end
						end
						CMD_DEL: begin
							if (word_zero) begin
								rsp_d.status = STAT_ZERO;
							end else begin
								ctl.op = OP_DELETE;
								if (found[DEPTH]) begin
									count_d = count_q - 1'b1;
								end else begin
									rsp_d.status = STAT_NOT_FOUND;
								end
							end
						end
						CMD_ITER: begin
							if (count_q != '0) begin
								ctl.op           = OP_ROTATE;
								rsp_d.data_out   = cell_data[0];
								rsp_d.item_valid = 1'b1;
								if (count_q != CNT_W'(1)) begin
									rsp_d.last = 1'b0;
									left_d     = count_q - 1'b1;
									state_d    = FSM_ITER;
								end
							end
						end
						default: begin
						end
					endcase
					rsp_d.count = count_d;
				end
			end
			FSM_ITER: begin
				// emit head, rotate the chain, drop one from the run
				ctl.op           = OP_ROTATE;
				rsp_valid_d      = 1'b1;
				rsp_d.status     = STAT_OK;
				rsp_d.data_out   = cell_data[0];
				rsp_d.item_valid = 1'b1;
				rsp_d.count      = count_q;
				rsp_d.last       = left_q == CNT_W'(1);
				left_d           = left_q - 1'b1;
				if (left_q == CNT_W'(1)) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			left_q      <= left_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_iter_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_ITER |-> count_q != '0 && left_q != '0)
		else $error("iterate run on empty queue");

	a_iter_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_ITER |=> rsp_valid)
		else $error("iterate cycle without a response");

	a_item_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.item_valid |-> rsp.data_out != '0)
		else $error("stored word read back as zero");
`endif

endmodule
